[hw/rtl/gba_pkg.sv]
// Package for the grid belief accumulator.
// Holds the sequencer state type and the fixed field widths; depends on nothing.
`default_nettype none

package gba_pkg;

    localparam int POS_W    = 6;
    localparam int WEIGHT_W = 16;
    localparam int BELIEF_W = 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_SCAN,
        S_OWN,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/gba_ram.sv]
// Generic single-write, single-read memory with a registered read port.
// Used for the bin belief store; depends on nothing.
`default_nettype none

module gba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 25
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/grid_belief_accumulator.sv]
// Grid belief accumulator: a square grid of saturating belief bins over a 50 by 50 field.
// Each request clears the grid or adds a weight to one bin, then reports the centre of the
// highest bin and the best position in the 3x3 neighbourhood of the request's own bin.
// Once accepted, a request runs through to its result and holds it until taken; the block
// is ready again in the cycle after the result is taken. The accepting cycle issues the read
// of the own bin (adds only), S_ADD writes it back (adds only), S_SCAN lets the single read
// port of the belief memory walk the 3x3 neighbourhood, reading each in-grid neighbour other
// than the own bin, S_OWN chooses the winner and S_OUT presents the result, where the block
// waits, not ready, until the result is taken. The highest bin is tracked on each add, so no
// full scan is needed. Bins cleared by reset or by a clear request read as zero through a
// valid bit per bin, so no clearing pass runs.
`default_nettype none

module grid_belief_accumulator #(
    parameter int BINS_PER_SIDE = 5,
    parameter int BIN_SIZE      = 10
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic                         i_command,
    input  wire logic [gba_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic [gba_pkg::POS_W-1:0]    i_pos_y,
    input  wire logic [gba_pkg::WEIGHT_W-1:0] i_weight,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [gba_pkg::POS_W-1:0]    o_best_x,
    output logic      [gba_pkg::POS_W-1:0]    o_best_y,
    output logic      [gba_pkg::POS_W-1:0]    o_near_x,
    output logic      [gba_pkg::POS_W-1:0]    o_near_y
);

    import gba_pkg::*;

    localparam int NB   = BINS_PER_SIDE * BINS_PER_SIDE;
    localparam int RW   = $clog2(BINS_PER_SIDE);
    localparam int IW   = $clog2(NB);
    localparam int NPOS = 2 ** POS_W;
    localparam int HALF = BIN_SIZE / 2;

    t_state                r_state, n_state;
    logic [POS_W-1:0]      r_px, n_px;
    logic [POS_W-1:0]      r_py, n_py;
    logic [WEIGHT_W-1:0]   r_w, n_w;
    logic [RW-1:0]         r_row, n_row;
    logic [RW-1:0]         r_col, n_col;
    logic [IW-1:0]         r_own, n_own;
    logic [BELIEF_W-1:0]   r_own_val, n_own_val;
    logic [IW-1:0]         r_max_idx, n_max_idx;
    logic [RW-1:0]         r_max_row, n_max_row;
    logic [RW-1:0]         r_max_col, n_max_col;
    logic [BELIEF_W-1:0]   r_max_val, n_max_val;
    logic [NB-1:0]         r_valid, n_valid;
    logic                  r_rd_valid;
    logic [1:0]            r_dr, n_dr;
    logic [1:0]            r_dc, n_dc;
    logic                  r_pend, n_pend;
    logic [RW-1:0]         r_pend_row, n_pend_row;
    logic [RW-1:0]         r_pend_col, n_pend_col;
    logic [BELIEF_W-1:0]   r_best_val, n_best_val;
    logic [RW-1:0]         r_best_row, n_best_row;
    logic [RW-1:0]         r_best_col, n_best_col;
    logic                  r_found, n_found;
    logic                  r_out_valid, n_out_valid;
    logic [POS_W-1:0]      r_best_x, n_best_x;
    logic [POS_W-1:0]      r_best_y, n_best_y;
    logic [POS_W-1:0]      r_near_x, n_near_x;
    logic [POS_W-1:0]      r_near_y, n_near_y;

    logic [RW-1:0]         w_axis_lut [NPOS];
    logic [RW-1:0]         w_in_row, w_in_col;
    logic [IW-1:0]         w_in_own;
    logic                  w_ram_we;
    logic [IW-1:0]         w_ram_waddr;
    logic [BELIEF_W-1:0]   w_ram_wdata;
    logic [IW-1:0]         w_ram_raddr;
    logic [BELIEF_W-1:0]   w_rdata;
    logic [BELIEF_W-1:0]   w_rd_val;
    logic [BELIEF_W:0]     w_sum;
    logic [BELIEF_W-1:0]   w_sat;
    logic [RW:0]           w_rr, w_cc;
    logic                  w_cand_ok;
    logic [RW-1:0]         w_cand_row, w_cand_col;
    logic [IW-1:0]         w_cand_idx;

    genvar g;
    for (g = 0; g < NPOS; g++) begin : g_axis
        localparam int Q = g / BIN_SIZE;
        assign w_axis_lut[g] = RW'((Q > BINS_PER_SIDE - 1) ? BINS_PER_SIDE - 1 : Q);
    end

    assign w_in_row = w_axis_lut[i_pos_y];
    assign w_in_col = w_axis_lut[i_pos_x];
    assign w_in_own = IW'(int'(w_in_row) * BINS_PER_SIDE + int'(w_in_col));

    assign w_rd_val = r_rd_valid ? w_rdata : '0;
    assign w_sum    = {1'b0, w_rd_val} + (BELIEF_W + 1)'(r_w);
    assign w_sat    = w_sum[BELIEF_W] ? '1 : w_sum[BELIEF_W-1:0];

    assign w_rr       = (RW + 1)'(r_row) + (RW + 1)'(r_dr);
    assign w_cc       = (RW + 1)'(r_col) + (RW + 1)'(r_dc);
    assign w_cand_ok  = (w_rr != '0) && (w_rr <= (RW + 1)'(BINS_PER_SIDE))
                     && (w_cc != '0) && (w_cc <= (RW + 1)'(BINS_PER_SIDE))
                     && !((r_dr == 2'd1) && (r_dc == 2'd1));
    assign w_cand_row = RW'(w_rr - (RW + 1)'(1));
    assign w_cand_col = RW'(w_cc - (RW + 1)'(1));
    assign w_cand_idx = IW'(int'(w_cand_row) * BINS_PER_SIDE + int'(w_cand_col));

    gba_ram #(
        .WIDTH(BELIEF_W),
        .DEPTH(NB)
    ) u_bins (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_ram_waddr),
        .i_wdata(w_ram_wdata),
        .i_raddr(w_ram_raddr),
        .o_rdata(w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_max_idx   <= '0;
            r_max_row   <= '0;
            r_max_col   <= '0;
            r_max_val   <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_max_idx   <= n_max_idx;
            r_max_row   <= n_max_row;
            r_max_col   <= n_max_col;
            r_max_val   <= n_max_val;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
            r_rd_valid  <= r_valid[w_ram_raddr];
        end
        r_px       <= n_px;
        r_py       <= n_py;
        r_w        <= n_w;
        r_row      <= n_row;
        r_col      <= n_col;
        r_own      <= n_own;
        r_own_val  <= n_own_val;
        r_dr       <= n_dr;
        r_dc       <= n_dc;
        r_pend_row <= n_pend_row;
        r_pend_col <= n_pend_col;
        r_best_val <= n_best_val;
        r_best_row <= n_best_row;
        r_best_col <= n_best_col;
        r_best_x   <= n_best_x;
        r_best_y   <= n_best_y;
        r_near_x   <= n_near_x;
        r_near_y   <= n_near_y;
    end

    always_comb begin
        n_state     = r_state;
        n_px        = r_px;
        n_py        = r_py;
        n_w         = r_w;
        n_row       = r_row;
        n_col       = r_col;
        n_own       = r_own;
        n_own_val   = r_own_val;
        n_max_idx   = r_max_idx;
        n_max_row   = r_max_row;
        n_max_col   = r_max_col;
        n_max_val   = r_max_val;
        n_valid     = r_valid;
        n_dr        = r_dr;
        n_dc        = r_dc;
        n_pend      = r_pend;
        n_pend_row  = r_pend_row;
        n_pend_col  = r_pend_col;
        n_best_val  = r_best_val;
        n_best_row  = r_best_row;
        n_best_col  = r_best_col;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_best_x    = r_best_x;
        n_best_y    = r_best_y;
        n_near_x    = r_near_x;
        n_near_y    = r_near_y;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_own;
        w_ram_wdata = w_sat;
        w_ram_raddr = '0;
        o_ready     = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_px       = i_pos_x;
                    n_py       = i_pos_y;
                    n_w        = i_weight;
                    n_row      = w_in_row;
                    n_col      = w_in_col;
                    n_own      = w_in_own;
                    n_dr       = '0;
                    n_dc       = '0;
                    n_pend     = 1'b0;
                    n_best_val = '0;
                    n_found    = 1'b0;
                    if (i_command) begin
                        n_valid   = '0;
                        n_max_idx = '0;
                        n_max_row = '0;
                        n_max_col = '0;
                        n_max_val = '0;
                        n_own_val = '0;
                        n_state   = S_SCAN;
                    end else begin
                        w_ram_raddr = w_in_own;
                        n_state     = S_ADD;
                    end
                end
            end
            S_ADD: begin
                w_ram_we         = 1'b1;
                n_valid[r_own]   = 1'b1;
                n_own_val        = w_sat;
                if (r_own == r_max_idx) begin
                    n_max_val = w_sat;
                end else if ((w_sat > r_max_val)
                          || ((w_sat == r_max_val) && (r_own < r_max_idx))) begin
                    n_max_idx = r_own;
                    n_max_row = r_row;
                    n_max_col = r_col;
                    n_max_val = w_sat;
                end
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_pend && (w_rd_val > r_best_val)) begin
                    n_best_val = w_rd_val;
                    n_best_row = r_pend_row;
                    n_best_col = r_pend_col;
                    n_found    = 1'b1;
                end
                n_pend = 1'b0;
                if (r_dr != 2'd3) begin
                    if (w_cand_ok) begin
                        w_ram_raddr = w_cand_idx;
                        n_pend      = 1'b1;
                        n_pend_row  = w_cand_row;
                        n_pend_col  = w_cand_col;
                    end
                    if (r_dc == 2'd2) begin
                        n_dc = '0;
                        n_dr = r_dr + 2'd1;
                    end else begin
                        n_dc = r_dc + 2'd1;
                    end
                end else begin
                    n_state = S_OWN;
                end
            end
            S_OWN: begin
                n_best_x = POS_W'(int'(r_max_col) * BIN_SIZE + HALF);
                n_best_y = POS_W'(int'(r_max_row) * BIN_SIZE + HALF);
                if ((r_own_val > r_best_val) || !r_found) begin
                    n_near_x = r_px;
                    n_near_y = r_py;
                end else begin
                    n_near_x = POS_W'(int'(r_best_col) * BIN_SIZE);
                    n_near_y = POS_W'(int'(r_best_row) * BIN_SIZE);
                end
                n_out_valid = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_best_x = r_best_x;
    assign o_best_y = r_best_y;
    assign o_near_x = r_near_x;
    assign o_near_y = r_near_y;

    a_max_covers_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OWN) |-> (r_max_val >= r_own_val))
        else $error("Tracked maximum is below the updated own bin.");

    a_max_bin_written: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_max_val != '0) |-> r_valid[r_max_idx])
        else $error("Non-zero maximum points at a bin that was never written.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("New request taken while a result is outstanding.");

    a_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (!o_valid && !o_ready))
        else $error("Sequencer did not start work on an accepted request.");

endmodule

`default_nettype wire
